FILE: src/pwsa_pkg.sv
// package for the projective warp source address unit
// holds payload structs and register index codes; no dependencies
package pwsa_pkg;

  localparam int CFG_W = 64;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_ROW0_XY  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_OFF = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_XY  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_OFF = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_XY  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_OFF = 3'd5;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd7;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
  } in_t;

  typedef struct packed {
    logic        in_bounds;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [23:0] src_index;
  } out_t;

endpackage

FILE: src/pwsa_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing; numerator and denominator are unsigned
module pwsa_div #(
  parameter int NW = 47,
  parameter int DW = 46,
  parameter int QW = 14,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  // stage registers
  logic [NW-1:0]    rem [QW+1];
  logic [DW-1:0]    dd  [QW+1];
  logic [QW-1:0]    q   [QW+1];
  logic [QW+1-1:0]  vld;
  logic [TW-1:0]    tg  [QW+1];
  logic             ov  [QW+1];

  // entry: quotient too big for QW bits when num >= den << QW
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      q[0]   <= '0;
      tg[0]  <= tag_in;
      ov[0]  <= ({{QW{1'b0}}, num} >> QW) >= {{(NW+QW-DW){1'b0}}, den};
    end
  end

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      localparam int SH = QW - 1 - s;
      logic [NW+QW-1:0] trial;
      logic             take;
      assign trial = {{(NW+QW-DW){1'b0}}, dd[s]} << SH;
      assign take  = {{QW{1'b0}}, rem[s]} >= trial;
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s+1] <= 1'b0;
        end else if (en) begin
          vld[s+1] <= vld[s];
        end
        if (en) begin
          rem[s+1] <= take ? NW'({{QW{1'b0}}, rem[s]} - trial) : rem[s];
          dd[s+1]  <= dd[s];
          q[s+1]   <= q[s] | (QW'(take) << SH);
          tg[s+1]  <= tg[s];
          ov[s+1]  <= ov[s];
        end
      end
    end
  endgenerate

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign ovf       = ov[QW];
  assign tag_out   = tg[QW];

endmodule

FILE: src/projective_warp_source_address_unit.sv
// projective warp source address unit, nearest neighbor
// throughput one request per cycle while the output is not held
// the divider pipeline (one quotient bit per stage) sets the latency
// a full pipeline stalls as a whole only while the output is held and full
// rst is synchronous: clears valid bits and sets the identity transform, 256x256
module projective_warp_source_address_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pwsa_pkg::in_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pwsa_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  logic [pwsa_pkg::IDX_W-1:0] cfg_index,
  input  logic [pwsa_pkg::CFG_W-1:0] cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int QW    = 14;
  localparam int PW    = 45;   // 32x13 signed product
  localparam int SW    = 47;   // signed sum
  localparam int MW    = 46;   // magnitude
  localparam int NW    = MW + 1;
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  // configuration registers
  logic [63:0] r0xy, r1xy, r2xy;
  logic [31:0] r0o, r1o, r2o;
  logic [12:0] wreg, hreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0xy <= ONE << 32;
      r0o  <= '0;
      r1xy <= ONE;
      r1o  <= '0;
      r2xy <= '0;
      r2o  <= ONE[31:0];
      wreg <= 13'd256;
      hreg <= 13'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwsa_pkg::REG_ROW0_XY:  r0xy <= cfg_data;
        pwsa_pkg::REG_ROW0_OFF: r0o  <= cfg_data[31:0];
        pwsa_pkg::REG_ROW1_XY:  r1xy <= cfg_data;
        pwsa_pkg::REG_ROW1_OFF: r1o  <= cfg_data[31:0];
        pwsa_pkg::REG_ROW2_XY:  r2xy <= cfg_data;
        pwsa_pkg::REG_ROW2_OFF: r2o  <= cfg_data[31:0];
        pwsa_pkg::REG_WIDTH:    wreg <= cfg_data[12:0];
        pwsa_pkg::REG_HEIGHT:   hreg <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [DIM_W-1:0] wc, hc;
  assign wc = ({19'd0, wreg} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(wreg);
  assign hc = ({19'd0, hreg} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(hreg);

  // global enable: whole pipe advances unless output is held full
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: six products
  logic             v1;
  logic signed [PW-1:0] p [6];
  logic signed [31:0]   o1 [3];
  logic signed [12:0] xs, ys;
  assign xs = $signed({1'b0, in_data.out_x});
  assign ys = $signed({1'b0, in_data.out_y});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      p[0] <= PW'($signed(r0xy[63:32]) * xs);
      p[1] <= PW'($signed(r0xy[31:0])  * ys);
      p[2] <= PW'($signed(r1xy[63:32]) * xs);
      p[3] <= PW'($signed(r1xy[31:0])  * ys);
      p[4] <= PW'($signed(r2xy[63:32]) * xs);
      p[5] <= PW'($signed(r2xy[31:0])  * ys);
      o1[0] <= $signed(r0o);
      o1[1] <= $signed(r1o);
      o1[2] <= $signed(r2o);
    end
  end

  // stage 2: sums a, b, c
  logic v2;
  logic signed [SW-1:0] sa, sb, sc;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sa <= SW'(p[0]) + SW'(p[1]) + SW'(o1[0]);
      sb <= SW'(p[2]) + SW'(p[3]) + SW'(o1[1]);
      sc <= SW'(p[4]) + SW'(p[5]) + SW'(o1[2]);
    end
  end

  // stage 3: magnitudes, 2n+d and 2d, sign checks
  logic v3;
  logic [NW-1:0] na, nb;
  logic [MW-1:0] d2;
  logic          nega, negb, cz, aneg, bneg;
  logic [MW-1:0] ma, mb, mc;
  assign ma = MW'(sa[SW-1] ? -sa : sa);
  assign mb = MW'(sb[SW-1] ? -sb : sb);
  assign mc = MW'(sc[SW-1] ? -sc : sc);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      na   <= {ma, 1'b0} + NW'(mc);
      nb   <= {mb, 1'b0} + NW'(mc);
      d2   <= {mc[MW-2:0], 1'b0};
      cz   <= (sc == '0);
      nega <= (sa != '0) && (sa[SW-1] != sc[SW-1]);
      negb <= (sb != '0) && (sb[SW-1] != sc[SW-1]);
    end
  end
  assign aneg = nega;
  assign bneg = negb;

  // two dividers carry the flags as tags: the shared zero flag and each one's own sign flag
  localparam int TW = 2;
  logic          vda, vdb, ova, ovb;
  logic [QW-1:0] qa, qb;
  logic [TW-1:0] ta, tb;

  pwsa_div #(.NW(NW), .DW(MW), .QW(QW), .TW(TW)) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .num(na), .den(d2),
    .tag_in({cz, aneg}), .out_valid(vda), .quo(qa), .ovf(ova), .tag_out(ta)
  );
  pwsa_div #(.NW(NW), .DW(MW), .QW(QW), .TW(TW)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .num(nb), .den(d2),
    .tag_in({cz, bneg}), .out_valid(vdb), .quo(qb), .ovf(ovb), .tag_out(tb)
  );

  // stage: bounds check; negative zero quotient is fine
  logic v5, ok5;
  logic [11:0] sx5, sy5;
  logic [DIM_W-1:0] w5;
  logic oka, okb;
  assign oka = !ova && !(ta[0] && qa != '0) && ({2'b0, qa} < 16'(wc));
  assign okb = !ovb && !(tb[0] && qb != '0) && ({2'b0, qb} < 16'(hc));
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= vda;
    if (en) begin
      ok5 <= !ta[1] && oka && okb;
      sx5 <= qa[11:0];
      sy5 <= qb[11:0];
      w5  <= wc;
    end
  end

  // output stage: index multiply
  logic [23:0] idx;
  assign idx = 24'(24'(sy5) * 24'(w5)) + 24'(sx5);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v5;
    if (en) begin
      out_data.in_bounds <= ok5;
      out_data.src_x     <= ok5 ? sx5 : '0;
      out_data.src_y     <= ok5 ? sy5 : '0;
      out_data.src_index <= ok5 ? idx : '0;
    end
  end

  // both dividers move together
  a_div_lock: assert property (@(posedge clk) disable iff (rst) vda == vdb)
    else $error("divider valids differ");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.in_bounds |-> out_data.src_index == '0)
    else $error("out of bounds index not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result lost under stall");

endmodule

FILE: dv/projective_warp_source_address_unit_tb.sv
// testbench for the projective warp source address unit
// directed table plus random requests checked against a behavioral mapping predictor
// depends on src/pwsa_pkg.sv and src/projective_warp_source_address_unit.sv
module projective_warp_source_address_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 4096;
  localparam int LATENCY = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pwsa_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwsa_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [pwsa_pkg::IDX_W-1:0] cfg_index = '0;
  logic [pwsa_pkg::CFG_W-1:0] cfg_data = '0;

  projective_warp_source_address_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("projective_warp_source_address_unit_tb: done, errors");
    $finish;
  end

  // predictor copy of the transform registers
  logic [63:0] m_row_xy [3];
  logic [31:0] m_row_off [3];
  logic [12:0] m_width, m_height;

  pwsa_pkg::out_t addr_queue [$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_inb = 0;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;

  function automatic longint row_value(int r, longint x, longint y);
    longint cx, cy, co;
    cx = longint'($signed(m_row_xy[r][63:32]));
    cy = longint'($signed(m_row_xy[r][31:0]));
    co = longint'($signed(m_row_off[r]));
    return cx * x + cy * y + co;
  endfunction

  // rounded quotient, half away from zero; ok clear when c is zero or result negative
  function automatic bit round_quot(longint num, longint den, output longint q);
    longint n, d;
    bit neg;
    q = 0;
    if (den == 0) return 1'b0;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (neg && q != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pwsa_pkg::out_t source_address(pwsa_pkg::in_t req);
    longint a, b, c, sx, sy, w, h;
    bit ok;
    pwsa_pkg::out_t res;
    a = row_value(0, req.out_x, req.out_y);
    b = row_value(1, req.out_x, req.out_y);
    c = row_value(2, req.out_x, req.out_y);
    w = m_width > MAX_DIM ? MAX_DIM : m_width;
    h = m_height > MAX_DIM ? MAX_DIM : m_height;
    ok = round_quot(a, c, sx);
    if (ok) ok = round_quot(b, c, sy);
    if (ok) ok = (sx < w) && (sy < h);
    res = '0;
    if (ok) begin
      res.in_bounds = 1'b1;
      res.src_x = sx[11:0];
      res.src_y = sy[11:0];
      res.src_index = 24'(sy * w + sx);
    end
    return res;
  endfunction

  task automatic write_reg(logic [pwsa_pkg::IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pwsa_pkg::REG_ROW0_XY:  m_row_xy[0] = val;
      pwsa_pkg::REG_ROW0_OFF: m_row_off[0] = val[31:0];
      pwsa_pkg::REG_ROW1_XY:  m_row_xy[1] = val;
      pwsa_pkg::REG_ROW1_OFF: m_row_off[1] = val[31:0];
      pwsa_pkg::REG_ROW2_XY:  m_row_xy[2] = val;
      pwsa_pkg::REG_ROW2_OFF: m_row_off[2] = val[31:0];
      pwsa_pkg::REG_WIDTH:    m_width = val[12:0];
      default:                m_height = val[12:0];
    endcase
  endtask

  task automatic load_matrix(logic [31:0] c00, logic [31:0] c01, logic [31:0] c02,
                             logic [31:0] c10, logic [31:0] c11, logic [31:0] c12,
                             logic [31:0] c20, logic [31:0] c21, logic [31:0] c22);
    write_reg(pwsa_pkg::REG_ROW0_XY, {c00, c01});
    write_reg(pwsa_pkg::REG_ROW0_OFF, {32'd0, c02});
    write_reg(pwsa_pkg::REG_ROW1_XY, {c10, c11});
    write_reg(pwsa_pkg::REG_ROW1_OFF, {32'd0, c12});
    write_reg(pwsa_pkg::REG_ROW2_XY, {c20, c21});
    write_reg(pwsa_pkg::REG_ROW2_OFF, {32'd0, c22});
  endtask

  // one request; expected result is typed in or taken from the predictor
  // valid stays high across back to back requests and drops only for idling
  task automatic send_req(logic [11:0] x, logic [11:0] y, bit fixed,
                          pwsa_pkg::out_t want);
    pwsa_pkg::in_t req;
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.out_x = x;
    req.out_y = y;
    in_valid <= 1'b1;
    in_data <= req;
    addr_queue.push_back(fixed ? want : source_address(req));
    do @(posedge clk); while (!in_ready);
    n_req++;
    @(negedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (addr_queue.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off when asked
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pwsa_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (addr_queue.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = addr_queue.pop_front();
        n_res++;
        if (out_data.in_bounds) n_inb++;
        if (out_data.in_bounds !== want.in_bounds) begin
          $error("in_bounds exp %0d got %0d", want.in_bounds, out_data.in_bounds);
          errors++;
        end
        if (out_data.src_x !== want.src_x) begin
          $error("src_x exp %0d got %0d", want.src_x, out_data.src_x);
          errors++;
        end
        if (out_data.src_y !== want.src_y) begin
          $error("src_y exp %0d got %0d", want.src_y, out_data.src_y);
          errors++;
        end
        if (out_data.src_index !== want.src_index) begin
          $error("src_index exp %0d got %0d", want.src_index, out_data.src_index);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [11:0]    x;
    logic [11:0]    y;
    bit             fixed;
    pwsa_pkg::out_t want;
  } vec_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;

  task automatic rand_phase(int count, int mode);
    logic [11:0] x, y;
    for (int i = 0; i < count; i++) begin
      if (mode == 0 || $urandom_range(0, 4) == 0) begin
        x = 12'($urandom);
        y = 12'($urandom);
      end else begin
        x = 12'($urandom_range(0, m_width > 0 ? m_width : 1));
        y = 12'($urandom_range(0, m_height > 0 ? m_height : 1));
      end
      send_req(x, y, 1'b0, '0);
    end
  endtask

  function automatic logic [31:0] rcoef(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return 32'(v);
  endfunction

  initial begin
    vec_t dir [$];
    m_row_xy[0] = {ONE, 32'd0};
    m_row_xy[1] = {32'd0, ONE};
    m_row_xy[2] = '0;
    m_row_off[0] = '0;
    m_row_off[1] = '0;
    m_row_off[2] = ONE;
    m_width = 13'd256;
    m_height = 13'd256;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity after reset: corners, edges, out of range inputs
    dir.push_back('{12'd0, 12'd0, 1, '{1'b1, 12'd0, 12'd0, 24'd0}});
    dir.push_back('{12'd255, 12'd255, 1, '{1'b1, 12'd255, 12'd255, 24'd65535}});
    dir.push_back('{12'd256, 12'd3, 1, '{1'b0, 12'd0, 12'd0, 24'd0}});
    dir.push_back('{12'd3, 12'd256, 1, '{1'b0, 12'd0, 12'd0, 24'd0}});
    dir.push_back('{12'd4095, 12'd4095, 1, '{1'b0, 12'd0, 12'd0, 24'd0}});
    dir.push_back('{12'd1, 12'd2, 1, '{1'b1, 12'd1, 12'd2, 24'd513}});
    dir.push_back('{12'hAAA, 12'h555, 1, '{1'b0, 12'd0, 12'd0, 24'd0}});
    dir.push_back('{12'h055, 12'h0AA, 0, '0});
    foreach (dir[i]) send_req(dir[i].x, dir[i].y, dir[i].fixed, dir[i].want);
    drain();

    // zero denominator: every pixel out of bounds
    write_reg(pwsa_pkg::REG_ROW2_OFF, 64'd0);
    send_req(12'd0, 12'd0, 1'b1, '0);
    send_req(12'd10, 12'd7, 1'b1, '0);
    drain();

    // half scale with negative offset: rounding ties and small negatives
    load_matrix(HALF, 32'd0, -32'sd19661, 32'd0, HALF, -32'sd32768,
                32'd0, 32'd0, ONE);
    for (int i = 0; i < 6; i++) send_req(12'(i), 12'(i), 1'b0, '0);
    drain();
    // negative denominator, max width and height saturating
    write_reg(pwsa_pkg::REG_WIDTH, 64'h1FFF);
    write_reg(pwsa_pkg::REG_HEIGHT, 64'h1FFF);
    load_matrix(-ONE, 32'd0, 32'd0, 32'd0, -ONE, 32'd0, 32'd0, 32'd0, -ONE);
    send_req(12'd4095, 12'd4095, 1'b1, '{1'b1, 12'd4095, 12'd4095, 24'hFFFFFF});
    send_req(12'd0, 12'd4095, 1'b0, '0);
    drain();
    // extreme coefficients
    load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(12'd4095, 12'd0, 1'b0, '0);
    send_req(12'd0, 12'd4095, 1'b0, '0);
    send_req(12'd4095, 12'd4095, 1'b0, '0);
    drain();
    // zero dimension and width one
    write_reg(pwsa_pkg::REG_WIDTH, 64'd0);
    write_reg(pwsa_pkg::REG_HEIGHT, 64'd1);
    load_matrix(ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE);
    send_req(12'd0, 12'd0, 1'b1, '0);
    drain();
    write_reg(pwsa_pkg::REG_WIDTH, 64'd1);
    send_req(12'd0, 12'd0, 1'b1, '{1'b1, 12'd0, 12'd0, 24'd0});
    send_req(12'd1, 12'd0, 1'b1, '0);
    drain();

    // random phases over several transforms; projective rows keep c mostly positive
    for (int p = 0; p < 8; p++) begin
      write_reg(pwsa_pkg::REG_WIDTH, 64'($urandom_range(1, p == 7 ? 8191 : 4096)));
      write_reg(pwsa_pkg::REG_HEIGHT, 64'($urandom_range(1, p == 6 ? 8191 : 4096)));
      case (p % 4)
        0: load_matrix(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                       32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                       32'($urandom));
        1: load_matrix(ONE + rcoef(30000), rcoef(30000), rcoef(2000000),
                       rcoef(30000), ONE + rcoef(30000), rcoef(2000000),
                       32'd0, 32'd0, ONE);
        2: load_matrix(ONE + rcoef(20000), rcoef(20000), rcoef(1000000),
                       rcoef(20000), ONE + rcoef(20000), rcoef(1000000),
                       rcoef(20), rcoef(20), ONE + rcoef(30000));
        default: load_matrix(rcoef(200000), rcoef(200000), rcoef(100000000),
                             rcoef(200000), rcoef(200000), rcoef(100000000),
                             rcoef(100), rcoef(100), rcoef(200000));
      endcase
      if (p == 3) hold_long = 1'b1;
      if (p == 7) quiet = 1'b1;
      rand_phase(65, p % 4 == 0 ? 0 : 1);
      drain();
    end

    $display("covered %0d requests, %0d results, %0d in bounds", n_req, n_res, n_inb);
    $display("transforms: identity, zero denominator, rounding, negation, extremes, random");
    if (errors == 0 && addr_queue.size() == 0) begin
      $display("projective_warp_source_address_unit_tb: done, clean");
    end else begin
      if (addr_queue.size() != 0) $error("%0d results never arrived", addr_queue.size());
      $display("projective_warp_source_address_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
